FILE: hw/rtl/mi2_pkg.sv
// Shared constants, codes and lane result type for the 2x2 mutual information block.
`default_nettype none
package mi2_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MAX_TERMS_DEF   = 64;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_CELLS  = 4;
  localparam int WORK_FRAC  = 32;
  localparam int EPS_SHIFT  = 8;
  localparam int THR_W      = 25;
  localparam int EPS_W      = THR_W + EPS_SHIFT;
  // series sum stays below 4.5 * 2^32 for up to 1024 terms
  localparam int ACC_W      = 36;
  // log2 magnitude, acc * 2/ln2
  localparam int LG_W       = 38;
  localparam int SUM_W      = LG_W + 3;

  localparam logic [THR_W-1:0]     THR_RESET    = THR_W'(16);
  localparam logic [WORK_FRAC-1:0] TWO_OVER_LN2 = 32'd3098164009;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_CAP  = 2'd2;

  typedef struct packed {
    logic            done;
    logic            neg;
    logic            cap;
    logic [LG_W-1:0] part;
  } lane_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mutual_information_2x2.sv
// Top level: 2x2 mutual information in bits from four cell counts.
//
//  channel | signals                              | direction | moves
//  --------+--------------------------------------+-----------+--------------------------
//  item    | item_valid, item_stall, count_*      | in        | four cell counts
//  result  | result_valid, result_stall,          | out       | info_bits, status
//          | info_bits, status                    |           |
//  cfg     | cfg_valid, cfg_ready, cfg_data       | in        | term_threshold
//
// Four lanes, one per cell, each run an atanh series of up to MAX_TERMS terms, ended
// once a term falls below the threshold or by the term cap; the bit-serial term
// divide in the series loop dominates a lane's run time. The lane results are then
// merged into the result register.
// One item at a time: item_stall stays high from acceptance until the result is loaded,
// and the next item is taken while that result still waits for the sink.
// Reset is synchronous; it idles all lanes, drops result_valid and restores the threshold.
`default_nettype none
module mutual_information_2x2 #(
  parameter int COUNT_WIDTH = mi2_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_TERMS   = mi2_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS   = mi2_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic [COUNT_WIDTH-1:0]     count_both_one,
  input  wire logic [COUNT_WIDTH-1:0]     count_x_one_y_zero,
  input  wire logic [COUNT_WIDTH-1:0]     count_x_zero_y_one,
  input  wire logic [COUNT_WIDTH-1:0]     count_both_zero,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [FRAC_BITS:0]              info_bits,
  output logic [1:0]                      status,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mi2_pkg::THR_W-1:0]  cfg_data
);

  localparam int CW    = COUNT_WIDTH;
  localparam int NC    = mi2_pkg::NUM_CELLS;

  logic [mi2_pkg::THR_W-1:0] term_threshold;
  logic                      busy;
  logic                      zero;
  logic                      accept;
  logic                      all_done;
  logic                      go;
  logic [CW+1:0]             tot;
  logic [CW:0]               x1, x0, y1, y0;
  logic [CW-1:0]             cell_n  [NC];
  logic [CW:0]               cell_nx [NC];
  logic [CW:0]               cell_ny [NC];
  mi2_pkg::lane_res_t        lane_res [NC];

  // The register is only to be written while idle; the block does not enforce this, so accept every write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_threshold <= mi2_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      term_threshold <= cfg_data;
    end
  end

  // Marginals and total, formed straight from the ports at acceptance.
  assign x1  = (CW+1)'(count_both_one) + (CW+1)'(count_x_one_y_zero);
  assign x0  = (CW+1)'(count_x_zero_y_one) + (CW+1)'(count_both_zero);
  assign y1  = (CW+1)'(count_both_one) + (CW+1)'(count_x_zero_y_one);
  assign y0  = (CW+1)'(count_x_one_y_zero) + (CW+1)'(count_both_zero);
  assign tot = (CW+2)'(x1) + (CW+2)'(x0);

  assign cell_n[0] = count_both_one;      assign cell_nx[0] = x1; assign cell_ny[0] = y1;
  assign cell_n[1] = count_x_one_y_zero;  assign cell_nx[1] = x1; assign cell_ny[1] = y0;
  assign cell_n[2] = count_x_zero_y_one;  assign cell_nx[2] = x0; assign cell_ny[2] = y1;
  assign cell_n[3] = count_both_zero;     assign cell_nx[3] = x0; assign cell_ny[3] = y0;

  assign item_stall = busy;
  assign accept     = item_valid && !busy;

  for (genvar i = 0; i < NC; i++) begin : g_lane
    mi2_lane #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .MAX_TERMS   (MAX_TERMS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (accept),
      .n     (cell_n[i]),
      .nx    (cell_nx[i]),
      .ny    (cell_ny[i]),
      .tot   (tot),
      .eps   ({term_threshold, mi2_pkg::EPS_SHIFT'(0)}),
      .res   (lane_res[i])
    );
  end

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NC; i++) begin
      all_done = all_done & lane_res[i].done;
    end
  end

  // Load the result once every lane is finished and the result register is free.
  assign go = busy && all_done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (go) begin
      busy <= 1'b0;
    end
  end

  // Hold the empty-table flag for the merge.
  always_ff @(posedge clk) begin
    if (accept) begin
      zero <= (tot == '0);
    end
  end

  mi2_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .zero         (zero),
    .lane_res     (lane_res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .info_bits    (info_bits),
    .status       (status)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/mi2_lane.sv
// One cell lane: exact ratio divide, atanh series, log2 scaling and weighting.
`default_nettype none
module mi2_lane #(
  parameter int COUNT_WIDTH = mi2_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_TERMS   = mi2_pkg::MAX_TERMS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [COUNT_WIDTH-1:0]     n,
  input  wire logic [COUNT_WIDTH:0]       nx,
  input  wire logic [COUNT_WIDTH:0]       ny,
  input  wire logic [COUNT_WIDTH+1:0]     tot,
  input  wire logic [mi2_pkg::EPS_W-1:0]  eps,
  output mi2_pkg::lane_res_t              res
);

  localparam int CW       = COUNT_WIDTH;
  localparam int TOT_W    = CW + 2;
  localparam int P_W      = 2 * CW + 4;
  localparam int CNT_W    = $clog2(MAX_TERMS + 1);
  localparam int TD_W     = CNT_W + 2;
  localparam int WF       = mi2_pkg::WORK_FRAC;
  localparam int LG_W     = mi2_pkg::LG_W;
  localparam int ACC_W    = mi2_pkg::ACC_W;
  localparam int M_W      = CW + LG_W;
  localparam int STEP_MAX = (CW > LG_W) ? CW : LG_W;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_MULT = 14'b00000000000010,
    ST_DIFF = 14'b00000000000100,
    ST_BDIV = 14'b00000000001000,
    ST_SQ   = 14'b00000000010000,
    ST_POW  = 14'b00000000100000,
    ST_TDIV = 14'b00000001000000,
    ST_TACC = 14'b00000010000000,
    ST_LOG1 = 14'b00000100000000,
    ST_LOG2 = 14'b00001000000000,
    ST_NMUL = 14'b00010000000000,
    ST_NSET = 14'b00100000000000,
    ST_NDIV = 14'b01000000000000,
    ST_DONE = 14'b10000000000000
  } lane_state_t;

  lane_state_t          state;
  logic [CW-1:0]        n_r;
  logic [CW:0]          nx_r;
  logic [CW:0]          ny_r;
  logic [TOT_W-1:0]     tot_r;
  logic [P_W-1:0]       p;
  logic [P_W-1:0]       q;
  logic [P_W-1:0]       den;
  logic [P_W-1:0]       rem;
  logic                 neg;
  logic                 cap;
  logic [WF-1:0]        b;
  logic [WF-1:0]        sq;
  logic [WF-1:0]        pw;
  logic [WF-1:0]        tq;
  logic [TD_W-1:0]      trem;
  logic [ACC_W-1:0]     acc;
  logic [CNT_W-1:0]     count;
  logic [2*WF-1:0]      lo_prod;
  logic [ACC_W-1:0]     hi_prod;
  logic [LG_W-1:0]      lg;
  logic [M_W-1:0]       mprod;
  logic [TOT_W:0]       nrem;
  logic [LG_W-1:0]      nq;
  logic [STEP_W-1:0]    step;

  logic [P_W-1:0]       p_mul;
  logic [P_W-1:0]       q_mul;
  logic [P_W-1:0]       rem2;
  logic                 bge;
  logic [2*WF-1:0]      sq_mul;
  logic [2*WF-1:0]      pw_mul;
  logic [CNT_W:0]       dvs;
  logic [TD_W-1:0]      t2;
  logic                 tge;
  logic [2*WF-1:0]      lo_mul;
  logic [ACC_W-1:0]     hi_mul;
  logic [LG_W-1:0]      lg_sum;
  logic [M_W-1:0]       madd;
  logic [TOT_W:0]       nr2;
  logic                 nge;

  assign p_mul  = P_W'(n_r) * P_W'(tot_r);
  assign q_mul  = P_W'(nx_r) * P_W'(ny_r);
  assign rem2   = {rem[P_W-2:0], 1'b0};
  assign bge    = rem2 >= den;
  assign sq_mul = (2*WF)'(b) * (2*WF)'(b);
  assign pw_mul = (2*WF)'(pw) * (2*WF)'(sq);
  assign dvs    = {count, 1'b1};
  assign t2     = {trem[TD_W-2:0], tq[WF-1]};
  assign tge    = t2 >= TD_W'(dvs);
  assign lo_mul = (2*WF)'(acc[WF-1:0]) * (2*WF)'(mi2_pkg::TWO_OVER_LN2);
  assign hi_mul = ACC_W'(acc[ACC_W-1:WF]) * ACC_W'(mi2_pkg::TWO_OVER_LN2);
  assign lg_sum = (LG_W'(hi_prod) << 2) + LG_W'(lo_prod[2*WF-1:30]);
  assign madd   = n_r[CW-1] ? M_W'(lg) : '0;
  assign nr2    = {nrem[TOT_W-1:0], nq[LG_W-1]};
  assign nge    = nr2 >= (TOT_W+1)'(tot_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (start) begin
      n_r   <= n;
      nx_r  <= nx;
      ny_r  <= ny;
      tot_r <= tot;
      cap   <= 1'b0;
      neg   <= 1'b0;
      nq    <= '0;
      state <= (n == '0) ? ST_DONE : ST_MULT;
    end else begin
      unique case (state)
        ST_IDLE, ST_DONE: begin
          state <= state;
        end
        ST_MULT: begin
          p     <= p_mul;
          q     <= q_mul;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          neg   <= p < q;
          rem   <= (p < q) ? q - p : p - q;
          den   <= p + q;
          step  <= STEP_W'(WF - 1);
          state <= ST_BDIV;
        end
        ST_BDIV: begin
          rem <= bge ? rem2 - den : rem2;
          b   <= {b[WF-2:0], bge};
          if (step == '0) state <= ST_SQ;
          else step <= step - 1'b1;
        end
        ST_SQ: begin
          sq    <= sq_mul[2*WF-1:WF];
          pw    <= b;
          acc   <= ACC_W'(b);
          count <= CNT_W'(1);
          state <= ST_POW;
        end
        ST_POW: begin
          if (count >= CNT_W'(MAX_TERMS)) begin
            cap   <= 1'b1;
            state <= ST_LOG1;
          end else begin
            pw    <= pw_mul[2*WF-1:WF];
            tq    <= pw_mul[2*WF-1:WF];
            trem  <= '0;
            step  <= STEP_W'(WF - 1);
            state <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          trem <= tge ? t2 - TD_W'(dvs) : t2;
          tq   <= {tq[WF-2:0], tge};
          if (step == '0) state <= ST_TACC;
          else step <= step - 1'b1;
        end
        ST_TACC: begin
          acc   <= acc + ACC_W'(tq);
          count <= count + 1'b1;
          state <= ({1'b0, tq} < mi2_pkg::EPS_W'(eps)) ? ST_LOG1 : ST_POW;
        end
        ST_LOG1: begin
          lo_prod <= lo_mul;
          hi_prod <= hi_mul;
          state   <= ST_LOG2;
        end
        ST_LOG2: begin
          lg    <= lg_sum;
          mprod <= '0;
          step  <= STEP_W'(CW - 1);
          state <= ST_NMUL;
        end
        ST_NMUL: begin
          mprod <= (mprod << 1) + madd;
          n_r   <= n_r << 1;
          if (step == '0) state <= ST_NSET;
          else step <= step - 1'b1;
        end
        ST_NSET: begin
          nrem  <= (TOT_W+1)'(mprod[M_W-1:LG_W]);
          nq    <= mprod[LG_W-1:0];
          step  <= STEP_W'(LG_W - 1);
          state <= ST_NDIV;
        end
        ST_NDIV: begin
          nrem <= nge ? nr2 - (TOT_W+1)'(tot_r) : nr2;
          nq   <= {nq[LG_W-2:0], nge};
          if (step == '0) state <= ST_DONE;
          else step <= step - 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.done = (state == ST_DONE);
  assign res.neg  = neg;
  assign res.cap  = cap;
  assign res.part = nq;

endmodule
`default_nettype wire

FILE: hw/rtl/mi2_merge.sv
// Merge stage: signed sum of the lane parts, clamp, status and result register.
`default_nettype none
module mi2_merge #(
  parameter int FRAC_BITS = mi2_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic               zero,
  input  wire mi2_pkg::lane_res_t lane_res [mi2_pkg::NUM_CELLS],
  input  wire logic               result_stall,
  output logic                    result_valid,
  output logic [FRAC_BITS:0]      info_bits,
  output logic [1:0]              status
);

  localparam int SUM_W = mi2_pkg::SUM_W;
  localparam int SHIFT = mi2_pkg::WORK_FRAC - FRAC_BITS;
  localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] total;
  logic        [SUM_W-1:0] scaled;
  logic        [FRAC_BITS:0] info_next;
  logic                    any_cap;

  always_comb begin
    total   = '0;
    any_cap = 1'b0;
    for (int i = 0; i < mi2_pkg::NUM_CELLS; i++) begin
      if (lane_res[i].neg) total = total - $signed(SUM_W'(lane_res[i].part));
      else total = total + $signed(SUM_W'(lane_res[i].part));
      any_cap = any_cap | lane_res[i].cap;
    end
    scaled = $unsigned(total) >> SHIFT;
    if (total < 0) info_next = '0;
    else if (scaled > ONE) info_next = (FRAC_BITS+1)'(ONE);
    else info_next = (FRAC_BITS+1)'(scaled);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (zero) begin
        info_bits <= '0;
        status    <= mi2_pkg::STATUS_ZERO;
      end else begin
        info_bits <= info_next;
        status    <= any_cap ? mi2_pkg::STATUS_CAP : mi2_pkg::STATUS_OK;
      end
    end
  end

endmodule
`default_nettype wire
